// ===== rtl/tlvp_pkg.sv =====
// ============================================================================
// TLV record parser package
// Types, constants and codes shared by the parser top level and its result
// buffer.
// ============================================================================
package tlvp_pkg;

    // Number of distinct record types tracked for duplicate marking.
    localparam int MAX_TYPES  = 256;
    localparam int TYPE_IDX_W = $clog2(MAX_TYPES);

    // Configuration register.
    localparam int          LIMIT_W          = 9;
    localparam logic [8:0]  TYPE_LIMIT_RESET = 9'd256;
    localparam logic        REG_TYPE_LIMIT   = 1'b0;   // word index of type_limit

    // Result buffer geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_OK    = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // One result item.
    typedef struct packed {
        kind_t        kind;
        logic         duplicate;
        logic         record_end;
        logic [15:0]  record_type;
        logic [7:0]   value_byte;
        logic [15:0]  value_index;
    } result_t;

    // Results produced by one accepted byte: zero, one or two of them.
    typedef struct packed {
        logic [1:0]   count;
        result_t      first;
        result_t      second;
    } push_t;

endpackage

// ===== rtl/tlvp_out_fifo.sv =====
// ============================================================================
// TLV parser result buffer
// Small register queue that takes up to two results per cycle and hands out
// one per cycle on the output stream while the output is ready.
// ============================================================================
module tlvp_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  tlvp_pkg::push_t    push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output tlvp_pkg::result_t  out_item
);

    tlvp_pkg::result_t                  mem [tlvp_pkg::FIFO_DEPTH];
    logic [tlvp_pkg::FIFO_AW-1:0]       wr_ptr_reg;
    logic [tlvp_pkg::FIFO_AW-1:0]       wr_ptr_next;
    logic [tlvp_pkg::FIFO_AW-1:0]       wr_ptr_plus1;
    logic [tlvp_pkg::FIFO_AW-1:0]       rd_ptr_reg;
    logic [tlvp_pkg::FIFO_AW-1:0]       rd_ptr_next;
    logic [tlvp_pkg::FIFO_AW:0]         count_reg;
    logic [tlvp_pkg::FIFO_AW:0]         count_next;
    logic                               pop;

    // There must be space for the worst case of two results per byte.
    assign room      = (count_reg <= (tlvp_pkg::FIFO_AW+1)'(tlvp_pkg::FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill level arithmetic.
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + tlvp_pkg::FIFO_AW'(push.count);
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + (tlvp_pkg::FIFO_AW+1)'(push.count)
                       - (tlvp_pkg::FIFO_AW+1)'(pop);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage: the first result at the write pointer, the second after it.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

// ===== rtl/tlv_record_parser.sv =====
// Results are written into the result buffer when their byte is accepted.
// Throughput: one byte per cycle; a byte that yields two results needs two output
// transfers, and the four-entry buffer stalls input only when it holds more than two.
// Reset: asynchronous, active low; clears parser state, the seen-type flags and the buffer.
// The seen-type flags are flip-flops cleared at once, so no clearing pass follows reset.
// ============================================================================
// TLV record parser
// Parses a byte stream of records (16-bit type, 16-bit length, value bytes)
// and emits one result per value byte, plus empty-record, error and
// end-of-message results.
// ============================================================================
module tlv_record_parser (
    input  logic         clk,
    input  logic         rst_n,
    // Input byte stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    input  logic         s_tlast,     // last_byte
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,     // [15:0] record_type, [23:16] value_byte,
                                      // [39:24] value_index
    output logic [2:0]   m_tuser,     // [1:0] kind, [2] duplicate
    output logic         m_tlast,     // record_end
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {
        PH_TYPE_HI = 3'd0,
        PH_TYPE_LO = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_VALUE   = 3'd4
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [15:0]                       current_type_reg, current_type_next;
    logic [15:0]                       bytes_left_reg, bytes_left_next;
    logic [15:0]                       byte_position_reg, byte_position_next;
    logic                              discarding_reg, discarding_next;
    logic                              dup_reg, dup_next;
    logic [tlvp_pkg::MAX_TYPES-1:0]    seen_reg;
    logic [tlvp_pkg::LIMIT_W-1:0]      type_limit_reg;

    logic                              s_accept;
    logic                              cfg_write;
    logic [15:0]                       eff_limit;
    logic [15:0]                       type_lo;
    logic [15:0]                       len_full;
    logic [15:0]                       left_dec;
    logic                              fail;
    logic [15:0]                       fail_type;
    logic                              ok_emit;
    logic                              end_msg;
    logic                              seen_set;
    logic [tlvp_pkg::TYPE_IDX_W-1:0]   seen_idx;
    tlvp_pkg::result_t                 extra;
    tlvp_pkg::push_t                   push;
    logic                              fifo_room;
    tlvp_pkg::result_t                 out_item;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = fifo_room;

    // Configuration register: word index taken from address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == tlvp_pkg::REG_TYPE_LIMIT);
    assign prdata    = (paddr[2] == tlvp_pkg::REG_TYPE_LIMIT)
                       ? {{(32-tlvp_pkg::LIMIT_W){1'b0}}, type_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_limit_reg <= tlvp_pkg::TYPE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            type_limit_reg <= pwdata[tlvp_pkg::LIMIT_W-1:0];
        end
    end

    // Effective limit saturates at the number of tracked types.
    always_comb
    begin
        if (16'(type_limit_reg) > 16'(tlvp_pkg::MAX_TYPES))
        begin
            eff_limit = 16'(tlvp_pkg::MAX_TYPES);
        end
        else
        begin
            eff_limit = 16'(type_limit_reg);
        end
    end

    assign type_lo  = {current_type_reg[15:8], s_tdata};
    assign len_full = {bytes_left_reg[15:8], s_tdata};
    assign left_dec = bytes_left_reg - 16'd1;

    // Per-byte parse step: next state and up to two results.
    always_comb
    begin
        phase_next         = phase_reg;
        current_type_next  = current_type_reg;
        bytes_left_next    = bytes_left_reg;
        byte_position_next = byte_position_reg;
        discarding_next    = discarding_reg;
        dup_next           = dup_reg;
        fail               = 1'b0;
        fail_type          = current_type_reg;
        ok_emit            = 1'b0;
        end_msg            = 1'b0;
        seen_set           = 1'b0;
        seen_idx           = current_type_reg[tlvp_pkg::TYPE_IDX_W-1:0];
        push               = '0;
        extra              = '0;

        if (s_accept)
        begin
            if (discarding_reg)
            begin
                end_msg = s_tlast;
            end
            else
            begin
                case (phase_reg)
                    PH_TYPE_LO:
                    begin
                        current_type_next = type_lo;
                        fail_type         = type_lo;
                        if ((type_lo == 16'd0) || (type_lo >= eff_limit))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                            dup_next   = seen_reg[type_lo[tlvp_pkg::TYPE_IDX_W-1:0]];
                            fail       = s_tlast;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        bytes_left_next = {s_tdata, 8'h00};
                        phase_next      = PH_LEN_LO;
                        fail            = s_tlast;
                    end
                    PH_LEN_LO:
                    begin
                        bytes_left_next    = len_full;
                        byte_position_next = 16'd0;
                        if (len_full == 16'd0)
                        begin
                            push.count             = 2'd1;
                            push.first.kind        = tlvp_pkg::KIND_EMPTY;
                            push.first.record_type = current_type_reg;
                            push.first.record_end  = 1'b1;
                            push.first.duplicate   = dup_reg;
                            seen_set               = 1'b1;
                            phase_next             = PH_TYPE_HI;
                            ok_emit                = s_tlast;
                        end
                        else
                        begin
                            phase_next = PH_VALUE;
                            fail       = s_tlast;
                        end
                    end
                    PH_VALUE:
                    begin
                        bytes_left_next        = left_dec;
                        byte_position_next     = byte_position_reg + 16'd1;
                        push.count             = 2'd1;
                        push.first.kind        = tlvp_pkg::KIND_VALUE;
                        push.first.record_type = current_type_reg;
                        push.first.value_byte  = s_tdata;
                        push.first.value_index = byte_position_reg;
                        push.first.record_end  = (left_dec == 16'd0);
                        push.first.duplicate   = dup_reg;
                        if (left_dec == 16'd0)
                        begin
                            seen_set   = 1'b1;
                            phase_next = PH_TYPE_HI;
                            ok_emit    = s_tlast;
                        end
                        else
                        begin
                            fail = s_tlast;
                        end
                    end
                    default:
                    begin
                        // Type high byte; unused phase codes land here too.
                        current_type_next = {s_tdata, 8'h00};
                        fail_type         = {s_tdata, 8'h00};
                        phase_next        = PH_TYPE_LO;
                        fail              = s_tlast;
                    end
                endcase

                // Error and end-of-message results follow anything else from this byte.
                if (fail || ok_emit)
                begin
                    extra.kind        = fail ? tlvp_pkg::KIND_ERROR : tlvp_pkg::KIND_OK;
                    extra.record_type = fail ? fail_type : 16'd0;
                    if (push.count == 2'd0)
                    begin
                        push.first = extra;
                    end
                    else
                    begin
                        push.second = extra;
                    end
                    push.count = push.count + 2'd1;
                end

                if (fail && !s_tlast)
                begin
                    discarding_next = 1'b1;
                end
                else if (s_tlast)
                begin
                    end_msg = 1'b1;
                end
            end
        end

        // Message boundary: the parse position starts clean.
        if (end_msg)
        begin
            phase_next         = PH_TYPE_HI;
            current_type_next  = 16'd0;
            bytes_left_next    = 16'd0;
            byte_position_next = 16'd0;
            discarding_next    = 1'b0;
        end
    end

    // Parser state and seen-type flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_TYPE_HI;
            current_type_reg  <= 16'd0;
            bytes_left_reg    <= 16'd0;
            byte_position_reg <= 16'd0;
            discarding_reg    <= 1'b0;
            dup_reg           <= 1'b0;
            seen_reg          <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            current_type_reg  <= current_type_next;
            bytes_left_reg    <= bytes_left_next;
            byte_position_reg <= byte_position_next;
            discarding_reg    <= discarding_next;
            dup_reg           <= dup_next;
            if (end_msg)
            begin
                seen_reg <= '0;
            end
            else if (seen_set)
            begin
                seen_reg[seen_idx] <= 1'b1;
            end
        end
    end

    // Result buffer between the parser and the output stream.
    tlvp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (fifo_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {out_item.value_index, out_item.value_byte, out_item.record_type};
    assign m_tuser = {out_item.duplicate, out_item.kind};
    assign m_tlast = out_item.record_end;

    // A byte taken while discarding never produces a result.
    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && discarding_reg) |-> (push.count == 2'd0))
        else $error("result produced while discarding");

    // Every value byte outside discard yields at least one result.
    a_value_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !discarding_reg && (phase_reg == PH_VALUE)) |-> (push.count != 2'd0))
        else $error("value byte produced no result");

    // The last byte of a message always leaves the parser clean.
    a_message_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=>
            ((seen_reg == '0) && (phase_reg == PH_TYPE_HI) && !discarding_reg))
        else $error("parser state not cleared at end of message");

endmodule
